// File: rtl/grouped_bitmap_block_allocator_defines.svh
// Assertion helpers used by the allocator engine.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define GBBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define GBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gbba_pkg.sv
`default_nettype none

package gbba_pkg;

  localparam int BLK_W   = 14;
  localparam int CFG_AW  = 4;
  localparam logic [BLK_W-1:0] BLK_MAX = '1;

  // command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_FIRST_DATA_BLOCK = 2'd0;
  localparam logic [1:0] REG_TOTAL_BLOCKS     = 2'd1;
  localparam logic [1:0] REG_GROUPS_IN_USE    = 2'd2;
  localparam logic [1:0] REG_WRITE_LOCK       = 2'd3;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_RDONLY  = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_GSEL = 5'b00100,
    S_SCAN = 5'b01000,
    S_FREE = 5'b10000
  } state_e;

  typedef struct packed {
    logic             first_data_block;
    logic [BLK_W-1:0] total_blocks;
    logic [3:0]       groups_in_use;
    logic             write_lock;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/gbba_bitmap_ram.sv
`default_nettype none

module gbba_bitmap_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64,
  parameter int AW    = 7
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gbba_cfg_regs.sv
`default_nettype none

module gbba_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gbba_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output gbba_pkg::cfg_t                  cfg_o
);
  import gbba_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_FIRST_DATA_BLOCK: cfg_d.first_data_block = pwdata[0];
        REG_TOTAL_BLOCKS:     cfg_d.total_blocks     = pwdata[BLK_W-1:0];
        REG_GROUPS_IN_USE:    cfg_d.groups_in_use    = pwdata[3:0];
        REG_WRITE_LOCK:       cfg_d.write_lock       = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FIRST_DATA_BLOCK: prdata = {31'd0, cfg_q.first_data_block};
      REG_TOTAL_BLOCKS:     prdata = {{(32-BLK_W){1'b0}}, cfg_q.total_blocks};
      REG_GROUPS_IN_USE:    prdata = {28'd0, cfg_q.groups_in_use};
      REG_WRITE_LOCK:       prdata = {31'd0, cfg_q.write_lock};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_data_block <= 1'b0;
      cfg_q.total_blocks     <= BLK_W'(8192);
      cfg_q.groups_in_use    <= 4'd8;
      cfg_q.write_lock       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gbba_engine.sv
`default_nettype none

module gbba_engine #(
  parameter int GROUP_COUNT    = 8,
  parameter int BITS_PER_GROUP = 1024,
  parameter int WORD_BITS      = 64,
  parameter int AW             = 7
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  gbba_pkg::cfg_t                 cfg_i,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                command_i,
  input  wire logic [gbba_pkg::BLK_W-1:0] block_number_i,
  output logic                           done_o,
  output logic      [2:0]                status_o,
  output logic      [gbba_pkg::BLK_W-1:0] granted_block_o,
  output logic      [gbba_pkg::BLK_W-1:0] free_total_o,
  output logic                           mem_re_o,
  output logic      [AW-1:0]             mem_raddr_o,
  input  wire logic [WORD_BITS-1:0]      mem_rdata_i,
  output logic                           mem_we_o,
  output logic      [AW-1:0]             mem_waddr_o,
  output logic      [WORD_BITS-1:0]      mem_wdata_o
);
  import gbba_pkg::*;

  localparam int WORD_COUNT = GROUP_COUNT * BITS_PER_GROUP / WORD_BITS;
  localparam int WPG        = BITS_PER_GROUP / WORD_BITS;
  localparam int JW         = $clog2(WORD_BITS);
  localparam int GW         = $clog2(GROUP_COUNT + 1);
  localparam int GIW        = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int CW         = $clog2(BITS_PER_GROUP + 1);
  localparam int ABW0       = $clog2(GROUP_COUNT * BITS_PER_GROUP) + 2;
  localparam int ABW        = (ABW0 > BLK_W + 1) ? ABW0 : BLK_W + 1;
  localparam logic [WORD_BITS-1:0] ONES = '1;
  localparam logic [CW-1:0]        CNT_MAX = '1;

  state_e            state_q, state_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [GW-1:0]     g_q, g_d;
  logic              goal_q, goal_d;
  logic              first_q, first_d;
  logic [JW-1:0]     bit_q, bit_d;
  logic [ABW-1:0]    acc_q, acc_d;
  logic              inited_q, inited_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [BLK_W-1:0]  granted_q, granted_d;
  logic [BLK_W-1:0]  tot_q, tot_d;
  logic [CW-1:0]     cnt_q [GROUP_COUNT];
  logic [CW-1:0]     cnt_d [GROUP_COUNT];

  logic [GW-1:0]     act;
  logic [BLK_W-1:0]  fdb_ext;
  logic [BLK_W-1:0]  off;
  logic [31:0]       off_grp;
  logic              grp_ok;
  logic [GIW-1:0]    off_gidx;
  logic [AW-1:0]     off_word;
  logic [JW-1:0]     off_bit;
  logic [WORD_BITS-1:0] rd;
  logic [WORD_BITS-1:0] eff;
  logic [JW-1:0]     zpos;
  logic [GW-1:0]     cur_grp;
  logic [GIW-1:0]    cur_gidx;
  logic              cur_last;
  logic [CW-1:0]     init_cnt;
  logic [ABW-1:0]    acc_n;

  // absolute block number of bit zero of word w
  function automatic logic [ABW-1:0] word_base(input logic [AW-1:0] w, input logic fdb);
    word_base = (ABW'(w) << JW) + ABW'(fdb);
  endfunction

  // bits at or beyond total_blocks read as used
  function automatic logic [WORD_BITS-1:0] tail_mask(input logic [ABW-1:0] base,
                                                     input logic [BLK_W-1:0] total);
    logic [ABW:0] lim;
    lim = {1'b0, ABW'(total)} - {1'b0, base};
    if (lim[ABW]) begin
      tail_mask = ONES;
    end else if (lim >= (ABW+1)'(WORD_BITS)) begin
      tail_mask = '0;
    end else begin
      tail_mask = ONES << lim[JW-1:0];
    end
  endfunction

  function automatic logic [JW-1:0] first_zero(input logic [WORD_BITS-1:0] v);
    first_zero = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!v[j]) begin
        first_zero = JW'(j);
      end
    end
  endfunction

  assign act = (32'(cfg_i.groups_in_use) > GROUP_COUNT) ? GW'(GROUP_COUNT)
                                                        : GW'(cfg_i.groups_in_use);
  assign fdb_ext  = BLK_W'(cfg_i.first_data_block);
  assign off      = block_number_i - fdb_ext;
  assign off_grp  = 32'(off) / BITS_PER_GROUP;
  assign grp_ok   = off_grp < 32'(act);
  assign off_gidx = off_grp[GIW-1:0];
  assign off_word = AW'(32'(off) / WORD_BITS);
  assign off_bit  = JW'(32'(off) % WORD_BITS);

  assign rd       = inited_q ? mem_rdata_i : '0;
  assign cur_grp  = GW'(32'(cur_q) / WPG);
  assign cur_gidx = cur_grp[GIW-1:0];
  assign cur_last = (32'(cur_q) % WPG) == (WPG - 1);
  assign eff      = rd | tail_mask(word_base(cur_q, cfg_i.first_data_block),
                                   cfg_i.total_blocks)
                  | (first_q ? ~(ONES << bit_q) : '0);
  assign zpos     = first_zero(eff);

  // valid block count of the group that starts at word cur_q
  always_comb begin
    logic [ABW-1:0] base;
    logic [ABW-1:0] diff;
    base = word_base(cur_q, cfg_i.first_data_block);
    diff = ABW'(cfg_i.total_blocks) - base;
    if (cur_grp >= act || base >= ABW'(cfg_i.total_blocks)) begin
      init_cnt = '0;
    end else if (diff >= ABW'(BITS_PER_GROUP)) begin
      init_cnt = CW'(BITS_PER_GROUP);
    end else begin
      init_cnt = CW'(diff);
    end
  end

  assign acc_n = acc_q + (((32'(cur_q) % WPG) == 0) ? ABW'(init_cnt) : '0);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    g_d       = g_q;
    goal_d    = goal_q;
    first_d   = first_q;
    bit_d     = bit_q;
    acc_d     = acc_q;
    inited_d  = inited_q;
    done_d    = 1'b0;
    status_d  = status_q;
    granted_d = granted_q;
    tot_d     = tot_q;
    cnt_d     = cnt_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = rd;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          granted_d = '0;
          status_d  = ST_OK;
          case (command_i)
            CMD_INIT: begin
              cur_d   = '0;
              acc_d   = '0;
              state_d = S_INIT;
            end
            CMD_FREE: begin
              if (cfg_i.write_lock) begin
                status_d = ST_RDONLY;
                done_d   = 1'b1;
              end else if (block_number_i < fdb_ext || !grp_ok ||
                           block_number_i >= cfg_i.total_blocks) begin
                status_d = ST_RANGE;
                done_d   = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = off_word;
                cur_d       = off_word;
                bit_d       = off_bit;
                state_d     = S_FREE;
              end
            end
            CMD_ALLOC: begin
              if (cfg_i.write_lock) begin
                status_d = ST_RDONLY;
                done_d   = 1'b1;
              end else if (tot_q == '0) begin
                status_d = ST_NOSPACE;
                done_d   = 1'b1;
              end else if (block_number_i > fdb_ext && grp_ok &&
                           cnt_q[off_gidx] != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = off_word;
                cur_d       = off_word;
                bit_d       = off_bit;
                first_d     = 1'b1;
                goal_d      = 1'b1;
                state_d     = S_SCAN;
              end else begin
                g_d     = '0;
                goal_d  = 1'b0;
                state_d = S_GSEL;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      S_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_q;
        mem_wdata_o = tail_mask(word_base(cur_q, cfg_i.first_data_block),
                                cfg_i.total_blocks)
                    | ((cur_grp >= act) ? ONES : '0);
        if ((32'(cur_q) % WPG) == 0) begin
          cnt_d[cur_gidx] = init_cnt;
        end
        acc_d = acc_n;
        if (cur_q == AW'(WORD_COUNT - 1)) begin
          tot_d    = (acc_n > ABW'(BLK_MAX)) ? BLK_MAX : BLK_W'(acc_n);
          inited_d = 1'b1;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end

      S_GSEL: begin
        if (g_q >= act) begin
          status_d = ST_NOSPACE;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (cnt_q[g_q[GIW-1:0]] == '0) begin
          g_d = g_q + 1'b1;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(32'(g_q) * WPG);
          cur_d       = AW'(32'(g_q) * WPG);
          first_d     = 1'b0;
          state_d     = S_SCAN;
        end
      end

      S_SCAN: begin
        if (~&eff) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q;
          mem_wdata_o = rd | (WORD_BITS'(1) << zpos);
          if (cnt_q[cur_gidx] != '0) begin
            cnt_d[cur_gidx] = cnt_q[cur_gidx] - 1'b1;
          end
          if (tot_q != '0) begin
            tot_d = tot_q - 1'b1;
          end
          granted_d = BLK_W'(word_base(cur_q, cfg_i.first_data_block) + ABW'(zpos));
          status_d  = ST_OK;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else if (cur_last) begin
          first_d = 1'b0;
          if (goal_q) begin
            goal_d = 1'b0;
            g_d    = '0;
          end else begin
            g_d = g_q + 1'b1;
          end
          state_d = S_GSEL;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cur_q + 1'b1;
          cur_d       = cur_q + 1'b1;
          first_d     = 1'b0;
        end
      end

      S_FREE: begin
        if (!rd[bit_q]) begin
          status_d = ST_DOUBLE;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q;
          mem_wdata_o = rd & ~(WORD_BITS'(1) << bit_q);
          if (cnt_q[cur_gidx] != CNT_MAX) begin
            cnt_d[cur_gidx] = cnt_q[cur_gidx] + 1'b1;
          end
          if (tot_q != BLK_MAX) begin
            tot_d = tot_q + 1'b1;
          end
          status_d = ST_OK;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      inited_q <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      tot_q    <= '0;
      for (int i = 0; i < GROUP_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      inited_q <= inited_d;
      done_q   <= done_d;
      status_q <= status_d;
      tot_q    <= tot_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    g_q       <= g_d;
    goal_q    <= goal_d;
    first_q   <= first_d;
    bit_q     <= bit_d;
    acc_q     <= acc_d;
    granted_q <= granted_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_block_o = granted_q;
  assign free_total_o    = tot_q;

`include "grouped_bitmap_block_allocator_defines.svh"

  `GBBA_ASSERT_IMPL(a_done_idle, done_q, state_q == S_IDLE, "result while engine busy")
  `GBBA_ASSERT_IMPL(a_we_state, mem_we_o, state_q != S_IDLE && state_q != S_GSEL, "stray write")
  `GBBA_ASSERT_IMPL(a_grant_zero, done_q && status_q != ST_OK, granted_q == '0, "grant on fail")
  `GBBA_ASSERT_NEXT(a_start_taken, start && !busy, busy || done_q, "accepted transaction dropped")

endmodule

`default_nettype wire

// File: rtl/grouped_bitmap_block_allocator.sv
`default_nettype none

// Channel | Signals                                              | Accepted at
// --------+------------------------------------------------------+----------------------
// command | start, busy, command_i, block_number_i               | start & !busy
// result  | done_o, status_o, granted_block_o, free_total_o      | done_o strobe, no stall
// config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB access, pready high
//
// Rejects and unused codes are answered from idle without a bitmap access; free does one read.
// Init writes every bitmap word once, WORD_COUNT words (128 at defaults).
// Alloc reads one bitmap word per cycle while scanning: first the goal group from the
// goal word, then each group with a nonzero counter, from group 0, with a select step between.
// Reset (rst_ni, async low) clears counters; the bitmap reads as zero until the first init.
// busy is high while the engine is outside its idle state; results cannot be held off.

module grouped_bitmap_block_allocator #(
  parameter int GROUP_COUNT    = 8,    // power of two
  parameter int BITS_PER_GROUP = 1024, // power of two, multiple of WORD_BITS
  parameter int WORD_BITS      = 64    // power of two
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  command_i,
  input  wire logic [gbba_pkg::BLK_W-1:0]  block_number_i,
  output logic                             done_o,
  output logic      [2:0]                  status_o,
  output logic      [gbba_pkg::BLK_W-1:0]  granted_block_o,
  output logic      [gbba_pkg::BLK_W-1:0]  free_total_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gbba_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import gbba_pkg::*;

  localparam int WORD_COUNT = GROUP_COUNT * BITS_PER_GROUP / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  cfg_t                 cfg;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // configuration registers
  gbba_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // usage bitmap, one word per entry, 1 = used
  gbba_bitmap_ram #(
    .DEPTH (WORD_COUNT),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // read-modify-write sequencer with group and total counters
  gbba_engine #(
    .GROUP_COUNT    (GROUP_COUNT),
    .BITS_PER_GROUP (BITS_PER_GROUP),
    .WORD_BITS      (WORD_BITS),
    .AW             (AW)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .block_number_i  (block_number_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_block_o (granted_block_o),
    .free_total_o    (free_total_o),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata)
  );

endmodule

`default_nettype wire
